// ----- rtl/rrstp_pkg.sv -----
package rrstp_pkg;

  localparam int KIND_W = 3;
  localparam int ID_W = 4;
  localparam int MS_W = 32;
  localparam int TICK_W = 32;
  localparam int TPM_W = 10;
  localparam int STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 3'd0,
    KIND_ADD    = 3'd1,
    KIND_REMOVE = 3'd2,
    KIND_PICK   = 3'd3,
    KIND_YIELD  = 3'd4,
    KIND_SLEEP  = 3'd5,
    KIND_NOP6   = 3'd6,
    KIND_NOP7   = 3'd7
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_ADD_REFUSE = 2'd1,
    STATUS_NO_TASK    = 2'd2,
    STATUS_NO_CURRENT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_RUNNABLE = 2'd0,
    ST_SLEEPING = 2'd1,
    ST_RUNNING  = 2'd2,
    ST_UNUSED   = 2'd3
  } slot_state_t;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_TASK = 2'd1,
    MODE_IDLE = 2'd2,
    MODE_RSVD = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_SHIFT,
    BK_MUL,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    kind_t           kind;
    logic [ID_W-1:0] task_id;
    logic [MS_W-1:0] sleep_ms;
  } cmd_t;

  typedef struct packed {
    status_t         status;
    logic [ID_W-1:0] chosen_task;
    logic            chose_idle;
  } res_t;

endpackage

// ----- rtl/rrstp_if.sv -----
interface rrstp_cmd_if import rrstp_pkg::*; ();
  logic valid;
  logic ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0] task_id;
  logic [MS_W-1:0] sleep_ms;
  modport source (output valid, kind, task_id, sleep_ms, input ready);
  modport sink (input valid, kind, task_id, sleep_ms, output ready);
endinterface

interface rrstp_res_if import rrstp_pkg::*; ();
  logic valid;
  logic ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0] chosen_task;
  logic chose_idle;
  modport source (output valid, status, chosen_task, chose_idle, input ready);
  modport sink (input valid, status, chosen_task, chose_idle, output ready);
endinterface

interface rrstp_cfg_if import rrstp_pkg::*; ();
  logic valid;
  logic ready;
  logic [TPM_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- rtl/rrstp_queue.sv -----
module rrstp_queue import rrstp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_cmd
);

  cmd_t slots [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] fill;

  assign in_ready = fill != 2'd2;
  assign out_valid = fill != 2'd0;
  assign out_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      slots[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (in_valid && in_ready) begin
        wr_ptr <= ~wr_ptr;
      end
      if (out_valid && out_ready) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, in_valid && in_ready} - {1'b0, out_valid && out_ready};
    end
  end

endmodule

// ----- rtl/rrstp_front.sv -----
module rrstp_front import rrstp_pkg::*; (
  input  logic clk,
  input  logic rst,
  rrstp_cmd_if.sink cmd,
  output logic q_valid,
  input  logic q_ready,
  output cmd_t q_cmd
);

  cmd_t hold;
  logic full;

  assign cmd.ready = !full || q_ready;
  assign q_valid = full;
  assign q_cmd = hold;

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      hold.kind <= kind_t'(cmd.kind);
      hold.task_id <= cmd.task_id;
      hold.sleep_ms <= cmd.sleep_ms;
    end
    if (rst) begin
      full <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      full <= 1'b1;
    end else if (q_ready) begin
      full <= 1'b0;
    end
  end

endmodule

// ----- rtl/rrstp_back.sv -----
module rrstp_back import rrstp_pkg::*; #(
  parameter int MAX_TASKS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic [TPM_W-1:0] ticks_per_ms,
  input  logic q_valid,
  output logic q_ready,
  input  cmd_t q_cmd,
  rrstp_res_if.source res
);

  localparam int PW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);

  bk_state_t state, state_next;
  cmd_t cur;
  logic [ID_W-1:0] ring_order [MAX_TASKS];
  logic [CW-1:0] ring_count;
  logic [MAX_TASKS-1:0] slot_present;
  slot_state_t slot_state [MAX_TASKS];
  logic [TICK_W-1:0] slot_wake_tick [MAX_TASKS];
  logic [MAX_TASKS-1:0] wake_valid;
  logic [TICK_W-1:0] now_tick;
  logic [ID_W-1:0] current_slot;
  mode_t current_mode;
  logic [CW-1:0] pos;
  logic [CW-1:0] found;
  logic [ID_W-1:0] pick;
  logic mode;
  logic [TICK_W-1:0] prod;
  logic [TICK_W-1:0] wake_sum;
  res_t out_r;
  logic out_full;
  logic [PW-1:0] cur_idx;
  logic id_ok;
  logic [PW-1:0] id_idx;
  logic [ID_W-1:0] scan_id;
  logic [PW-1:0] scan_idx;
  logic scan_run;
  logic scan_elig;
  logic [TICK_W-1:0] scan_wake;

  assign res.valid = out_full;
  assign res.status = out_r.status;
  assign res.chosen_task = out_r.chosen_task;
  assign res.chose_idle = out_r.chose_idle;
  assign q_ready = state == BK_IDLE && (!out_full || res.ready);

  assign id_ok = {{(32-ID_W){1'b0}}, cur.task_id} < 32'(MAX_TASKS);
  assign id_idx = PW'(cur.task_id);
  assign cur_idx = PW'(current_slot);
  assign scan_id = ring_order[pos[PW-1:0]];
  assign scan_idx = PW'(scan_id);
  assign scan_wake = wake_valid[scan_idx] ? slot_wake_tick[scan_idx] : '0;
  // the current task is released in the first scan cycle and counts as runnable there
  assign scan_run = !mode && current_mode == MODE_TASK && current_slot == scan_id &&
    slot_present[scan_idx] && slot_state[scan_idx] == ST_RUNNING;
  assign scan_elig = slot_state[scan_idx] == ST_RUNNABLE || scan_run ||
    (slot_state[scan_idx] == ST_SLEEPING && scan_wake != '0 && scan_wake <= now_tick);
  assign wake_sum = now_tick + prod;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (q_valid && q_ready) begin
        state_next = BK_SCAN;
      end
      BK_SCAN: begin
        if (cur.kind == KIND_SLEEP) begin
          state_next = BK_MUL;
        end else if ((cur.kind != KIND_PICK && cur.kind != KIND_REMOVE) || pos >= ring_count) begin
          state_next = (cur.kind == KIND_PICK || cur.kind == KIND_REMOVE) ? BK_SHIFT : BK_DONE;
        end else if (cur.kind == KIND_REMOVE && (!id_ok || !slot_present[id_idx])) begin
          state_next = BK_SHIFT;
        end else if ((cur.kind == KIND_PICK && scan_elig) ||
                     (cur.kind == KIND_REMOVE && scan_id == cur.task_id)) begin
          state_next = BK_SHIFT;
        end
      end
      BK_SHIFT: begin
        if (cur.kind == KIND_REMOVE || found >= ring_count || pos == '0) begin
          state_next = BK_DONE;
        end
      end
      BK_MUL: state_next = BK_DONE;
      BK_DONE: state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    state <= rst ? BK_IDLE : state_next;
    if (rst) begin
      ring_count <= '0;
      slot_present <= '0;
      wake_valid <= '0;
      now_tick <= '0;
      current_slot <= '0;
      current_mode <= MODE_NONE;
      out_full <= 1'b0;
    end else begin
      if (res.ready) begin
        out_full <= 1'b0;
      end
      case (state)
        BK_IDLE: if (q_valid && q_ready) begin
          cur <= q_cmd;
          pos <= '0;
          found <= CW'(MAX_TASKS);
          out_r <= '{STATUS_OK, '0, 1'b0};
          mode <= 1'b0;
        end
        BK_SCAN: begin
          case (cur.kind)
            KIND_TICK: now_tick <= now_tick + 1'b1;
            KIND_ADD: begin
              if (!id_ok || slot_present[id_idx] || ring_count >= CW'(MAX_TASKS)) begin
                out_r.status <= STATUS_ADD_REFUSE;
              end else begin
                for (int i = MAX_TASKS - 1; i > 0; i--) begin
                  ring_order[i] <= ring_order[i-1];
                end
                ring_order[0] <= cur.task_id;
                ring_count <= ring_count + 1'b1;
                slot_present[id_idx] <= 1'b1;
                slot_state[id_idx] <= ST_RUNNABLE;
              end
            end
            KIND_REMOVE: begin
              if (!id_ok || !slot_present[id_idx]) begin
                out_r.status <= STATUS_NO_TASK;
                found <= ring_count;
              end else if (pos < ring_count && scan_id == cur.task_id) begin
                found <= pos;
              end else if (pos < ring_count) begin
                pos <= pos + 1'b1;
              end else begin
                found <= ring_count;
              end
            end
            KIND_PICK: begin
              if (!mode) begin
                mode <= 1'b1;
                if (current_mode == MODE_TASK && slot_present[cur_idx] &&
                    slot_state[cur_idx] == ST_RUNNING) begin
                  slot_state[cur_idx] <= ST_RUNNABLE;
                end
                current_mode <= MODE_NONE;
                current_slot <= '0;
              end
              if (pos < ring_count && scan_elig) begin
                found <= pos;
                pick <= scan_id;
              end else if (pos < ring_count) begin
                pos <= pos + 1'b1;
              end else begin
                found <= ring_count;
              end
            end
            KIND_YIELD: begin
              if (current_mode == MODE_NONE) begin
                out_r.status <= STATUS_NO_CURRENT;
              end else begin
                if (current_mode == MODE_TASK && slot_present[cur_idx] &&
                    slot_state[cur_idx] == ST_RUNNING) begin
                  slot_state[cur_idx] <= ST_RUNNABLE;
                end
                current_mode <= MODE_NONE;
                current_slot <= '0;
              end
            end
            KIND_SLEEP: prod <= cur.sleep_ms * {22'd0, ticks_per_ms};
            default: ;
          endcase
        end
        BK_SHIFT: begin
          if (cur.kind == KIND_REMOVE) begin
            if (found < ring_count) begin
              for (int i = 0; i < MAX_TASKS - 1; i++) begin
                if (CW'(i) >= found) begin
                  ring_order[i] <= ring_order[i+1];
                end
              end
              ring_count <= ring_count - 1'b1;
            end
            if (out_r.status == STATUS_OK) begin
              slot_present[id_idx] <= 1'b0;
              if (current_mode == MODE_TASK && current_slot == cur.task_id) begin
                current_mode <= MODE_NONE;
                current_slot <= '0;
              end
            end
            pos <= '0;
          end else if (found >= ring_count) begin
            out_r.chose_idle <= 1'b1;
            current_mode <= MODE_IDLE;
            current_slot <= '0;
          end else if (pos != '0) begin
            for (int i = 0; i < MAX_TASKS - 1; i++) begin
              if (CW'(i) + 1'b1 < ring_count) begin
                ring_order[i] <= ring_order[i+1];
              end else if (CW'(i) + 1'b1 == ring_count) begin
                ring_order[i] <= ring_order[0];
              end
            end
            if (ring_count == CW'(MAX_TASKS)) begin
              ring_order[MAX_TASKS-1] <= ring_order[0];
            end
            pos <= pos - 1'b1;
          end
          if (cur.kind == KIND_PICK && (found >= ring_count || pos == '0)) begin
            if (found < ring_count) begin
              slot_state[PW'(pick)] <= ST_RUNNING;
              current_mode <= MODE_TASK;
              current_slot <= pick;
              out_r.chosen_task <= pick;
            end
          end
        end
        BK_MUL: begin
          if (current_mode == MODE_NONE) begin
            out_r.status <= STATUS_NO_CURRENT;
          end else begin
            if (current_mode == MODE_TASK && slot_present[cur_idx]) begin
              slot_state[cur_idx] <= ST_SLEEPING;
              slot_wake_tick[cur_idx] <= wake_sum;
              wake_valid[cur_idx] <= 1'b1;
            end
            current_mode <= MODE_NONE;
            current_slot <= '0;
          end
        end
        BK_DONE: out_full <= 1'b1;
        default: ;
      endcase
      if (state == BK_SCAN && cur.kind == KIND_PICK && state_next == BK_SHIFT &&
          pos < ring_count) begin
        pos <= pos + 1'b1;
      end
    end
  end

endmodule

// ----- rtl/round_robin_sleep_task_picker.sv -----
// Round-robin task picker with sleeping tasks. Items pass a one-item front
// register and a two-entry queue into a sequencer that runs one item at a time
// and takes the next only once the previous result is taken. A sleep adds one
// registered multiply, a remove scans the ring until it finds its task (no
// scan when the task is absent), and a pick scans the ring for an eligible
// task and then rotates the ring so that the chosen task moves to its end, or
// falls to idle when no task in the ring is eligible. The user must write
// ticks_per_ms only while no item is in flight; the block itself does not enforce it.
module round_robin_sleep_task_picker import rrstp_pkg::*; #(
  parameter int MAX_TASKS = 16
) (
  input logic clk,
  input logic rst,
  rrstp_cfg_if.sink cfg,
  rrstp_cmd_if.sink cmd,
  rrstp_res_if.source res
);

  logic [TPM_W-1:0] ticks_per_ms;
  logic f_valid, f_ready, b_valid, b_ready;
  cmd_t f_cmd, b_cmd;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_ms <= TPM_W'(1);
    end else if (cfg.valid) begin
      ticks_per_ms <= cfg.data;
    end
  end

  rrstp_front u_front (
    .clk, .rst, .cmd,
    .q_valid(f_valid), .q_ready(f_ready), .q_cmd(f_cmd)
  );

  rrstp_queue u_queue (
    .clk, .rst,
    .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
    .out_valid(b_valid), .out_ready(b_ready), .out_cmd(b_cmd)
  );

  rrstp_back #(.MAX_TASKS(MAX_TASKS)) u_back (
    .clk, .rst, .ticks_per_ms,
    .q_valid(b_valid), .q_ready(b_ready), .q_cmd(b_cmd), .res
  );

endmodule
